/* rtl/b64d_pkg.sv */
// Package for the Base64 stream decoder: item types, queue sizing and
// the character-to-sextet map. No dependencies.
package b64d_pkg;

    // Input item: one character of Base64 text.
    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } b64d_in_t;

    // Result item: one decoded byte or the error marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       error;
    } b64d_out_t;

    // Result queue sizing.
    localparam int QueueDepth = 8;
    localparam int PtrW       = $clog2(QueueDepth);
    localparam int CountW     = $clog2(QueueDepth + 1);
    localparam int MaxPush    = 3;

    // Group of results produced by one item (count of valid slots, 0..3).
    typedef struct packed {
        logic [1:0]          count;
        b64d_out_t [MaxPush-1:0] res;
    } b64d_push_t;

    // Place of the next character within its quad.
    typedef enum logic [1:0] {
        QP_FIRST,
        QP_SECOND,
        QP_THIRD,
        QP_FOURTH
    } b64d_qpos_t;

    // Sextet codes above the alphabet.
    localparam logic [6:0] SEXTET_BAD = 7'd64;
    localparam logic [6:0] SEXTET_PAD = 7'd65;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

    // Standard alphabet; '=' gives the pad code, '?' and everything else is invalid.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] s;
        begin
            s = SEXTET_BAD;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                s = 7'(c - CHAR_UPPER_A);
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                s = 7'(c - CHAR_LOWER_A + 8'd26);
            end
            else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            begin
                s = 7'(c - CHAR_DIGIT_0 + 8'd52);
            end
            else if (c == CHAR_PLUS)
            begin
                s = 7'd62;
            end
            else if (c == CHAR_SLASH)
            begin
                s = 7'd63;
            end
            else if (c == CHAR_EQUALS)
            begin
                s = SEXTET_PAD;
            end
            return s;
        end
    endfunction

endpackage

/* rtl/b64d_decode.sv */
// Decode stage: input register, quad state and result formation.
// Depends on b64d_pkg.
module b64d_decode
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  b64d_in_t   item,
    output b64d_push_t push
);

    logic        valid_reg;
    b64d_in_t    item_reg;
    b64d_qpos_t  qpos_reg,  qpos_next;
    logic [17:0] store_reg, store_next;
    logic        pad3_reg,  pad3_next;
    logic        skip_reg,  skip_next;

    logic [6:0]  sx;
    logic        fin;
    logic        bad;
    logic        clear;
    logic [23:0] word;
    b64d_out_t   res0, res1, res2;
    logic [1:0]  n;

    always_comb
    begin
        sx         = char_to_sextet(item_reg.character);
        fin        = item_reg.final_char;
        bad        = 1'b0;
        clear      = 1'b0;
        word       = {store_reg, sx[5:0]};
        qpos_next  = qpos_reg;
        store_next = store_reg;
        pad3_next  = pad3_reg;
        skip_next  = skip_reg;
        res0       = '0;
        res1       = '0;
        res2       = '0;
        n          = 2'd0;

        if (valid_reg)
        begin
            if (skip_reg)
            begin
                if (fin)
                begin
                    skip_next = 1'b0;
                end
            end
            else
            begin
                case (qpos_reg)
                    QP_FIRST, QP_SECOND:
                    begin
                        if (sx[6])
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            store_next = {store_reg[11:0], sx[5:0]};
                            qpos_next  = (qpos_reg == QP_FIRST) ? QP_SECOND : QP_THIRD;
                            bad        = fin;
                        end
                    end
                    QP_THIRD:
                    begin
                        if (sx == SEXTET_BAD)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            pad3_next  = (sx == SEXTET_PAD);
                            store_next = {store_reg[11:0],
                                          (sx == SEXTET_PAD) ? 6'd0 : sx[5:0]};
                            qpos_next  = QP_FOURTH;
                            bad        = fin;
                        end
                    end
                    QP_FOURTH:
                    begin
                        clear = 1'b1;
                        if (sx == SEXTET_BAD)
                        begin
                            bad = 1'b1;
                        end
                        else if (sx == SEXTET_PAD)
                        begin
                            if (!fin)
                            begin
                                bad = 1'b1;
                            end
                            else if (pad3_reg)
                            begin
                                res0 = '{data_byte: store_reg[17:10], last_byte: 1'b1,
                                         error: 1'b0};
                                n    = 2'd1;
                            end
                            else
                            begin
                                res0 = '{data_byte: store_reg[17:10], last_byte: 1'b0,
                                         error: 1'b0};
                                res1 = '{data_byte: store_reg[9:2], last_byte: 1'b1,
                                         error: 1'b0};
                                n    = 2'd2;
                            end
                        end
                        else if (pad3_reg)
                        begin
                            bad = 1'b1;
                        end
                        else
                        begin
                            res0 = '{data_byte: word[23:16], last_byte: 1'b0, error: 1'b0};
                            res1 = '{data_byte: word[15:8],  last_byte: 1'b0, error: 1'b0};
                            res2 = '{data_byte: word[7:0],   last_byte: fin,  error: 1'b0};
                            n    = 2'd3;
                        end
                    end
                    default:
                    begin
                        bad = 1'b1;
                    end
                endcase

                if (bad)
                begin
                    // single error marker, then drop input up to the final flag
                    res0      = '{data_byte: 8'd0, last_byte: 1'b1, error: 1'b1};
                    res1      = '0;
                    res2      = '0;
                    n         = 2'd1;
                    skip_next = !fin;
                end

                if (bad || clear || fin)
                begin
                    qpos_next  = QP_FIRST;
                    store_next = '0;
                    pad3_next  = 1'b0;
                end
            end
        end

        push.count = n;
        push.res   = {res2, res1, res0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            qpos_reg  <= QP_FIRST;
            store_reg <= '0;
            pad3_reg  <= 1'b0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            qpos_reg  <= qpos_next;
            store_reg <= store_next;
            pad3_reg  <= pad3_next;
            skip_reg  <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

/* rtl/b64d_out_queue.sv */
// Result queue: takes up to three results a cycle, gives one a cycle when popped.
// Depends on b64d_pkg.
module b64d_out_queue
    import b64d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  b64d_push_t        push,
    input  logic              pop,
    output b64d_out_t         head,
    output logic [CountW-1:0] count
);

    b64d_out_t         mem [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PtrW'(push.count);
        rd_ptr_next = rd_ptr_reg + PtrW'(pop);
        count_next  = count_reg + CountW'(push.count) - CountW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MaxPush; k++)
        begin
            if (2'(k) < push.count)
            begin
                mem[wr_ptr_reg + PtrW'(k)] <= push.res[k];
            end
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* rtl/base64_stream_decoder_unit.sv */
// Base64 stream decoder, top level. Depends on b64d_pkg, b64d_decode, b64d_out_queue.
// A character that is taken is decoded in the next cycle; its results are written
//   into the result queue, from which they are then taken.
// Throughput: one character per cycle; stall rises only when the result queue
//   backs up (three bytes per quad leave at one per cycle).
// Reset (rst_n, async, active low) clears the quad state, the discard flag and the queue.
module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // character side
    input  logic      char_valid,
    output logic      char_stall,
    input  b64d_in_t  char_item,
    // decoded byte side
    output logic      byte_valid,
    input  logic      byte_stall,
    output b64d_out_t byte_item
);

    // Two parts: the decode stage (input register, quad state, result
    // forming) and a small result queue. An item in the decode stage never
    // waits there; stall guards room in the queue for the up to
    // three results of the next item.

    localparam int StallLimit = QueueDepth - 2 * MaxPush + MaxPush;

    b64d_push_t        push;
    logic [CountW-1:0] queue_count;
    logic [CountW:0]   fill_ahead;
    logic              char_take;
    logic              byte_take;

    // count now plus what the decode stage pushes now; the next item pushes
    // at most MaxPush more in the next cycle, pops ignored
    assign fill_ahead = {1'b0, queue_count} + (CountW + 1)'(push.count);
    assign char_stall = fill_ahead > (CountW + 1)'(StallLimit);
    assign char_take  = char_valid && !char_stall;

    assign byte_valid = queue_count != '0;
    assign byte_take  = byte_valid && !byte_stall;

    b64d_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (char_take),
        .item   (char_item),
        .push   (push)
    );

    b64d_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (byte_take),
        .head  (byte_item),
        .count (queue_count)
    );

`ifndef SYNTHESIS
    // the queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= CountW'(QueueDepth))
        else $error("result queue over depth");

    // a push never finds the queue short of room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> fill_ahead <= (CountW + 1)'(QueueDepth))
        else $error("push into full result queue");

    // the error marker is the last item of its string and carries a zero byte
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_item.error |-> byte_item.last_byte && byte_item.data_byte == 8'd0)
        else $error("malformed error item");
`endif

endmodule
